### src/dadf_pkg.sv
// Shared types, constants and arithmetic helpers for the anchor decode and filter block.
package dadf_pkg;

	localparam int NUM_CLASSES     = 80;
	localparam int NUM_MASK_COEFFS = 32;
	localparam int ROW_HEAD        = 5;
	localparam int ROW_LEN         = ROW_HEAD + NUM_CLASSES + NUM_MASK_COEFFS;
	localparam int POS_W           = $clog2(ROW_LEN);

	localparam int VAL_W     = 24;
	localparam int THR_W     = 23;
	localparam int GAIN_W    = 24;
	localparam int DIM_W     = 13;
	localparam int PIX_W     = 12;
	localparam int CLS_W     = 8;
	localparam int CFG_IDX_W = 3;

	localparam int PROD_W       = 2 * VAL_W;
	localparam int Q_SHIFT      = 12;
	localparam int NUM_W        = VAL_W + 3;
	localparam int CPROD_W      = NUM_W + GAIN_W + 1;
	localparam int CORNER_SHIFT = 29;
	localparam int CV_W         = CPROD_W - CORNER_SHIFT;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic signed [VAL_W-1:0] Q12_MINUS_ONE = -VAL_W'(4096);
	localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(1 << PIX_W);

	localparam logic KIND_HEADER = 1'b0;
	localparam logic KIND_COEFF  = 1'b1;

	// corner slots of a box
	localparam int EDGE_LEFT   = 0;
	localparam int EDGE_TOP    = 1;
	localparam int EDGE_RIGHT  = 2;
	localparam int EDGE_BOTTOM = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONF_THR,
		CFG_MIN_SIZE,
		CFG_MAX_SIZE,
		CFG_PAD_X,
		CFG_PAD_Y,
		CFG_GAIN,
		CFG_IMG_W,
		CFG_IMG_H
	} cfg_index_t;

	typedef enum logic [2:0] {
		SLOT_CX,
		SLOT_CY,
		SLOT_W,
		SLOT_H,
		SLOT_OBJ,
		SLOT_CLASS,
		SLOT_MASK
	} slot_t;

	typedef struct packed {
		logic [THR_W-1:0]  conf_thr;
		logic [THR_W-1:0]  min_size;
		logic [THR_W-1:0]  max_size;
		logic [THR_W-1:0]  pad_x;
		logic [THR_W-1:0]  pad_y;
		logic [GAIN_W-1:0] gain;
		logic [DIM_W-1:0]  img_w;
		logic [DIM_W-1:0]  img_h;
	} cfg_t;

	typedef struct packed {
		slot_t                    slot;
		logic                     last;
		logic [CLS_W-1:0]         cls;
		logic signed [VAL_W-1:0]  value;
	} entry_t;

	typedef logic [3:0][PIX_W-1:0] corner_set_t;

	typedef struct packed {
		logic                     kind;
		logic [PIX_W-1:0]         left;
		logic [PIX_W-1:0]         top;
		logic [PIX_W-1:0]         right;
		logic [PIX_W-1:0]         bottom;
		logic [CLS_W-1:0]         cls;
		logic signed [VAL_W-1:0]  best;
		logic signed [VAL_W-1:0]  coef;
		logic                     final_coef;
	} result_t;

	// Q24 product to Q12: round half up, then saturate to the value width
	function automatic logic signed [VAL_W-1:0] round_sat_q12(
		input logic signed [PROD_W-1:0] p
	);
		logic [PROD_W:0]          r;
		logic [PROD_W-Q_SHIFT:0]  s;
		logic signed [VAL_W-1:0]  res;
		r = {p[PROD_W-1], p} + (PROD_W+1)'(1 << (Q_SHIFT - 1));
		s = r[PROD_W:Q_SHIFT];
		if ((&s[PROD_W-Q_SHIFT:VAL_W-1]) || !(|s[PROD_W-Q_SHIFT:VAL_W-1])) begin
			res = s[VAL_W-1:0];
		end else if (s[PROD_W-Q_SHIFT]) begin
			res = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(VAL_W-1){1'b1}}};
		end
		return res;
	endfunction

	// truncate the Q29 corner to pixels and clip into the image
	function automatic logic [PIX_W-1:0] clip_corner(
		input logic signed [CPROD_W-1:0] p,
		input logic [DIM_W-1:0]          dim
	);
		logic [PIX_W-1:0] lim;
		logic [CV_W-1:0]  v;
		logic [PIX_W-1:0] res;
		if (dim == '0) begin
			lim = '0;
		end else if (dim > DIM_MAX) begin
			lim = '1;
		end else begin
			lim = PIX_W'(dim - DIM_W'(1));
		end
		v = p[CPROD_W-1:CORNER_SHIFT];
		if (p[CPROD_W-1] || (p == '0)) begin
			res = '0;
		end else if (v > CV_W'(lim)) begin
			res = lim;
		end else begin
			res = v[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

### src/detection_anchor_decode_filter_core.sv
// Anchor decode and filter: one row value in per cycle while the queue has room, box
// headers and scaled mask coefficients out. Values of a row arrive in the order cx, cy,
// w, h, objectness, the class scores, then the mask coefficients; the position inside a
// row is tracked here, so the first value after reset starts a row. The block sustains
// one value per clock unless the queue is full; a value's result, if any, passes
// through the queue, the product stage and the output register; the four-entry queue
// between the front end and the back end, with the output register, absorbs short
// stalls. The corner unit registers numerators, products and clipped corners from the
// height on, covered by the scores. Configuration writes take effect on the next cycle.
module detection_anchor_decode_filter_core
	import dadf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [GAIN_W-1:0]       cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] row_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    item_kind,
	output logic [PIX_W-1:0]        left,
	output logic [PIX_W-1:0]        top,
	output logic [PIX_W-1:0]        right,
	output logic [PIX_W-1:0]        bottom,
	output logic [CLS_W-1:0]        class_index,
	output logic signed [VAL_W-1:0] best_score,
	output logic signed [VAL_W-1:0] coefficient,
	output logic                    final_coefficient
);

	cfg_t    cfg_q;
	logic    push_valid;
	logic    push_ready;
	entry_t  push_data;
	logic    q_valid;
	logic    q_ready;
	entry_t  q_data;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conf_thr <= THR_W'(1024);
			cfg_q.min_size <= THR_W'(8192);
			cfg_q.max_size <= '1;
			cfg_q.pad_x    <= '0;
			cfg_q.pad_y    <= '0;
			cfg_q.gain     <= GAIN_W'(65536);
			cfg_q.img_w    <= DIM_W'(640);
			cfg_q.img_h    <= DIM_W'(640);
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_CONF_THR: cfg_q.conf_thr <= cfg_data[THR_W-1:0];
				CFG_MIN_SIZE: cfg_q.min_size <= cfg_data[THR_W-1:0];
				CFG_MAX_SIZE: cfg_q.max_size <= cfg_data[THR_W-1:0];
				CFG_PAD_X:    cfg_q.pad_x    <= cfg_data[THR_W-1:0];
				CFG_PAD_Y:    cfg_q.pad_y    <= cfg_data[THR_W-1:0];
				CFG_GAIN:     cfg_q.gain     <= cfg_data;
				CFG_IMG_W:    cfg_q.img_w    <= cfg_data[DIM_W-1:0];
				CFG_IMG_H:    cfg_q.img_h    <= cfg_data[DIM_W-1:0];
				default:      ;
			endcase
		end
	end

	dadf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.row_value  (row_value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	dadf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	dadf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (res)
	);

	assign item_kind         = res.kind;
	assign left              = res.left;
	assign top               = res.top;
	assign right             = res.right;
	assign bottom            = res.bottom;
	assign class_index       = res.cls;
	assign best_score        = res.best;
	assign coefficient       = res.coef;
	assign final_coefficient = res.final_coef;

endmodule

### src/dadf_queue.sv
// Short queue of classified row values between the front and the back.
module dadf_queue
	import dadf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  entry_t push_data,
	output logic   pop_valid,
	input  logic   pop_ready,
	output entry_t pop_data
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

### src/dadf_front.sv
// Front end: takes row values, tracks the row position and tags each value with its slot.
module dadf_front
	import dadf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] row_value,
	output logic                    push_valid,
	input  logic                    push_ready,
	output entry_t                  push_data
);

	logic [POS_W-1:0] pos_q;
	entry_t           tag;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign push_data  = tag;

	always_comb begin
		tag.value = row_value;
		tag.last  = 1'b0;
		tag.cls   = '0;
		if (pos_q == POS_W'(0)) begin
			tag.slot = SLOT_CX;
		end else if (pos_q == POS_W'(1)) begin
			tag.slot = SLOT_CY;
		end else if (pos_q == POS_W'(2)) begin
			tag.slot = SLOT_W;
		end else if (pos_q == POS_W'(3)) begin
			tag.slot = SLOT_H;
		end else if (pos_q == POS_W'(4)) begin
			tag.slot = SLOT_OBJ;
		end else if (pos_q < POS_W'(ROW_HEAD + NUM_CLASSES)) begin
			tag.slot = SLOT_CLASS;
			tag.cls  = CLS_W'(pos_q) - CLS_W'(ROW_HEAD);
			tag.last = (pos_q == POS_W'(ROW_HEAD + NUM_CLASSES - 1));
		end else begin
			tag.slot = SLOT_MASK;
			tag.last = (pos_q == POS_W'(ROW_LEN - 1));
		end
	end

	// advance the row position on every transfer, wrap at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_valid && in_ready) begin
			if (pos_q == POS_W'(ROW_LEN - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

### src/dadf_corner.sv
// Box corner unit: numerators, scaling by the gain, truncation and clipping.
module dadf_corner
	import dadf_pkg::*;
(
	input  logic                    clk,
	input  logic                    load,
	input  logic signed [VAL_W-1:0] cx,
	input  logic signed [VAL_W-1:0] cy,
	input  logic signed [VAL_W-1:0] w,
	input  logic signed [VAL_W-1:0] h,
	input  cfg_t                    cfg,
	output corner_set_t             corners
);

	logic signed [NUM_W-1:0]   num_q  [4];
	logic signed [CPROD_W-1:0] prod_q [4];
	corner_set_t               corner_q;
	logic signed [NUM_W-1:0]   cx2, cy2, w_e, h_e, px2, py2;
	logic signed [CPROD_W-1:0] gain_e;
	logic signed [NUM_W-1:0]   dnum   [4];

	assign cx2    = {cx[VAL_W-1], cx[VAL_W-1], cx, 1'b0};
	assign cy2    = {cy[VAL_W-1], cy[VAL_W-1], cy, 1'b0};
	assign w_e    = NUM_W'(w);
	assign h_e    = NUM_W'(h);
	assign px2    = {3'b000, cfg.pad_x, 1'b0};
	assign py2    = {3'b000, cfg.pad_y, 1'b0};
	assign gain_e = CPROD_W'($signed({1'b0, cfg.gain}));

	assign corners = corner_q;

	// capture numerators once the box height arrives
	always_ff @(posedge clk) begin
		if (load) begin
			num_q[EDGE_LEFT]   <= cx2 - w_e;
			num_q[EDGE_TOP]    <= cy2 - h_e;
			num_q[EDGE_RIGHT]  <= cx2 + w_e;
			num_q[EDGE_BOTTOM] <= cy2 + h_e;
		end
	end

	// subtract the letterbox padding with the current settings
	always_comb begin
		dnum[EDGE_LEFT]   = num_q[EDGE_LEFT] - px2;
		dnum[EDGE_TOP]    = num_q[EDGE_TOP] - py2;
		dnum[EDGE_RIGHT]  = num_q[EDGE_RIGHT] - px2;
		dnum[EDGE_BOTTOM] = num_q[EDGE_BOTTOM] - py2;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			prod_q[i] <= CPROD_W'(dnum[i]) * gain_e;
		end
		corner_q[EDGE_LEFT]   <= clip_corner(prod_q[EDGE_LEFT], cfg.img_w);
		corner_q[EDGE_TOP]    <= clip_corner(prod_q[EDGE_TOP], cfg.img_h);
		corner_q[EDGE_RIGHT]  <= clip_corner(prod_q[EDGE_RIGHT], cfg.img_w);
		corner_q[EDGE_BOTTOM] <= clip_corner(prod_q[EDGE_BOTTOM], cfg.img_h);
	end

endmodule

### src/dadf_back.sv
// Back end: anchor state, score products, arg-max, result forming and output register.
module dadf_back
	import dadf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    q_valid,
	output logic    q_ready,
	input  entry_t  q_data,
	input  cfg_t    cfg,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	// anchor header state, written as values leave the queue
	logic signed [VAL_W-1:0]  cx_q, cy_q, w_q, obj_q;
	logic                     alive_q;

	// the registered box height is only needed for the alive test, hold it here
	logic signed [VAL_W-1:0]  h_q;
	logic                     size_ok_h;

	// product stage
	logic                     valid_s1;
	slot_t                    slot_s1;
	logic                     last_s1;
	logic [CLS_W-1:0]         cls_s1;
	logic signed [PROD_W-1:0] prod_s1;

	// running arg-max and emission state
	logic signed [VAL_W-1:0]  best_q;
	logic [CLS_W-1:0]         class_q;
	logic                     emitting_q;

	logic                     out_valid_q;
	result_t                  res_q;

	logic                     pop;
	logic                     adv_s1;
	logic                     out_free;
	logic                     alive;
	logic signed [VAL_W-1:0]  score;
	logic                     better;
	logic signed [VAL_W-1:0]  best_next;
	logic [CLS_W-1:0]         class_next;
	logic                     hdr;
	logic                     coef;
	logic                     produce;
	corner_set_t              corners;
	result_t                  res_next;

	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = !valid_s1 || !(hdr || coef) || out_free;
	assign q_ready  = adv_s1;
	assign pop      = q_valid && adv_s1;
	assign produce  = valid_s1 && (hdr || coef) && out_free;

	assign out_valid = out_valid_q;
	assign out_data  = res_q;

	assign alive = (q_data.value >= $signed({1'b0, cfg.conf_thr}))
		&& (w_q >= $signed({1'b0, cfg.min_size}))
		&& (w_q <= $signed({1'b0, cfg.max_size}));

	dadf_corner u_corner (
		.clk     (clk),
		.load    (pop && (q_data.slot == SLOT_H)),
		.cx      (cx_q),
		.cy      (cy_q),
		.w       (w_q),
		.h       (q_data.value),
		.cfg     (cfg),
		.corners (corners)
	);

	assign size_ok_h = (h_q >= $signed({1'b0, cfg.min_size}))
		&& (h_q <= $signed({1'b0, cfg.max_size}));

	always_ff @(posedge clk) begin
		if (pop) begin
			case (q_data.slot)
				SLOT_CX:  cx_q  <= q_data.value;
				SLOT_CY:  cy_q  <= q_data.value;
				SLOT_W:   w_q   <= q_data.value;
				SLOT_H:   h_q   <= q_data.value;
				SLOT_OBJ: obj_q <= q_data.value;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
		end else if (pop && (q_data.slot == SLOT_OBJ)) begin
			alive_q <= alive && size_ok_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			slot_s1 <= q_data.slot;
			last_s1 <= q_data.last;
			cls_s1  <= q_data.cls;
			prod_s1 <= PROD_W'(q_data.value) * PROD_W'(obj_q);
		end
	end

	always_comb begin
		score      = round_sat_q12(prod_s1);
		better     = (slot_s1 == SLOT_CLASS) && (best_q < score);
		best_next  = better ? score : best_q;
		class_next = better ? cls_s1 : class_q;
		hdr        = (slot_s1 == SLOT_CLASS) && last_s1 && alive_q
			&& (best_next >= $signed({1'b0, cfg.conf_thr}));
		coef       = (slot_s1 == SLOT_MASK) && emitting_q;
	end

	always_comb begin
		res_next            = '0;
		res_next.kind       = hdr ? KIND_HEADER : KIND_COEFF;
		if (hdr) begin
			res_next.left   = corners[EDGE_LEFT];
			res_next.top    = corners[EDGE_TOP];
			res_next.right  = corners[EDGE_RIGHT];
			res_next.bottom = corners[EDGE_BOTTOM];
			res_next.cls    = class_next;
			res_next.best   = best_next;
		end else begin
			res_next.coef       = score;
			res_next.final_coef = last_s1;
		end
	end

	// clear at row start, update the arg-max, open and close mask emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q     <= Q12_MINUS_ONE;
			class_q    <= '0;
			emitting_q <= 1'b0;
		end else if (valid_s1 && adv_s1) begin
			case (slot_s1)
				SLOT_CX: begin
					best_q     <= Q12_MINUS_ONE;
					class_q    <= '0;
					emitting_q <= 1'b0;
				end
				SLOT_CLASS: begin
					best_q  <= best_next;
					class_q <= class_next;
					if (hdr) begin
						emitting_q <= 1'b1;
					end
				end
				SLOT_MASK: begin
					if (last_s1) begin
						emitting_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			res_q <= res_next;
		end
	end

endmodule
